[hw/rtl/jets_pkg.sv]
// ----------------------------------------------------------------------------
// jets_pkg: shared types and constants of the julia escape-time pixel unit
// Fixed-point formats, saturation helper, colour mix table, channel structs.
// ----------------------------------------------------------------------------
package jets_pkg;

	// field widths
	localparam int COORD_W    = 12;
	localparam int CFG_W      = 32;
	localparam int ITER_W     = 10;
	localparam int NCOL_W     = 11;
	localparam int CADDR_W    = 3;
	localparam int COLOR_W    = 8;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 64;

	// arithmetic
	localparam int INDEX_BITS   = 12;
	localparam int ESCAPE_LIMIT = 100;
	localparam int FRAC_W = 28;
	localparam int Q_W    = 44;
	localparam int SUM_W  = 46;
	localparam int PROD_W = COORD_W + 1 + CFG_W;
	localparam int MAG_W  = Q_W - 1;
	localparam int LO_W   = (MAG_W + 1) / 2;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int FULL_W = 2 * MAG_W;

	localparam logic [COORD_W-1:0] IDX_MASK = COORD_W'((longint'(1) << INDEX_BITS) - 1);

	localparam logic signed [Q_W-1:0]   Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0]   Q_MIN   = -Q_MAX;
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(Q_MAX);
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX;
	localparam logic signed [Q_W-1:0]   LIMIT_Q = Q_W'(longint'(ESCAPE_LIMIT) << FRAC_W);

	// divide by three for values below 1024
	localparam int DIV3_MUL = 683;
	localparam int DIV3_SH  = 11;
	localparam int DIV3_W   = 2 * ITER_W;

	// input queue
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);

	// colour mixes, bit 2 red, bit 1 green, bit 0 blue; set picks 255-dim
	localparam logic [2:0] MIX_TABLE [8] = '{
		3'b000, 3'b100, 3'b010, 3'b001, 3'b110, 3'b011, 3'b101, 3'b111
	};

	typedef enum logic [CADDR_W-1:0] {
		REG_C_REAL, REG_C_IMAG, REG_X_ORIGIN, REG_Y_ORIGIN,
		REG_STEP_X, REG_STEP_Y, REG_MAX_ITER, REG_NUM_COLORS
	} cfg_reg_t;

	typedef enum logic [1:0] {PR_XX, PR_YY, PR_XY} prod_tag_t;

	typedef struct packed {
		logic [CFG_W-1:0]  c_real;
		logic [CFG_W-1:0]  c_imag;
		logic [CFG_W-1:0]  x_origin;
		logic [CFG_W-1:0]  y_origin;
		logic [CFG_W-1:0]  step_x;
		logic [CFG_W-1:0]  step_y;
		logic [ITER_W-1:0] max_iter;
		logic [NCOL_W-1:0] num_colors;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [Q_W-1:0]     x;
		logic [Q_W-1:0]     y;
	} q_entry_t;

	typedef struct packed {
		logic            valid;
		prod_tag_t       tag;
		logic [Q_W-1:0]  a;
		logic [Q_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic            valid;
		prod_tag_t       tag;
		logic [Q_W-1:0]  p;
	} mul_rsp_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [ITER_W-1:0]  k;
	} px_res_t;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
		if (v > SUM_MAX) begin
			return Q_MAX;
		end else if (v < SUM_MIN) begin
			return Q_MIN;
		end else begin
			return v[Q_W-1:0];
		end
	endfunction

endpackage

[hw/rtl/jets_front.sv]
// ----------------------------------------------------------------------------
// jets_front: start point of a pixel
// Multiplies the indices by the steps, then adds the origins with saturation.
// ----------------------------------------------------------------------------
module jets_front import jets_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] in_col,
	input  logic [COORD_W-1:0] in_row,
	input  logic               q_full,
	output logic               q_push,
	output q_entry_t           q_data
);

	logic signed [COORD_W:0]   col_sx, row_sx;
	logic signed [PROD_W-1:0]  px_c, py_c;
	logic signed [PROD_W-1:0]  px_s1, py_s1;
	logic [COORD_W-1:0]        col_s1, row_s1;
	logic                      v_s1;

	assign col_sx = {1'b0, in_col & IDX_MASK};
	assign row_sx = {1'b0, in_row & IDX_MASK};
	assign px_c   = PROD_W'(col_sx) * PROD_W'($signed(cfg.step_x));
	assign py_c   = PROD_W'(row_sx) * PROD_W'($signed(cfg.step_y));

	assign in_ready = !v_s1 || !q_full;
	assign q_push   = v_s1 && !q_full;

	assign q_data.col = col_s1;
	assign q_data.row = row_s1;
	assign q_data.x   = sat_q(SUM_W'(px_s1) + SUM_W'($signed(cfg.x_origin)));
	assign q_data.y   = sat_q(SUM_W'(py_s1) + SUM_W'($signed(cfg.y_origin)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_s1  <= px_c;
			py_s1  <= py_c;
			col_s1 <= in_col;
			row_s1 <= in_row;
		end
	end

endmodule

[hw/rtl/jets_fifo.sv]
// ----------------------------------------------------------------------------
// jets_fifo: short queue between front and iteration engine
// Show-ahead register queue of start points.
// ----------------------------------------------------------------------------
module jets_fifo import jets_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output q_entry_t pop_data,
	output logic     empty
);

	q_entry_t           mem [FQ_DEPTH];
	logic [FQ_AW-1:0]   wr_q, rd_q;
	logic [FQ_AW:0]     cnt_q;
	logic               do_push, do_pop;

	assign full     = (cnt_q == (FQ_AW+1)'(FQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FQ_AW+1)'(FQ_DEPTH))
		else $error("queue fill count beyond depth");
`endif

endmodule

[hw/rtl/jets_qmul.sv]
// ----------------------------------------------------------------------------
// jets_qmul: pipelined Q16.28 multiplier
// Sign-magnitude product from four half-width partials, truncated and
// saturated; operands, partials, sums and result are registered in turn.
// ----------------------------------------------------------------------------
module jets_qmul import jets_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [Q_W-1:0]            a_abs, b_abs;
	logic [MAG_W-1:0]          am_s1, bm_s1;
	logic [2*LO_W-1:0]         p00_s2, p00_s3;
	logic [LO_W+HI_W-1:0]      p01_s2, p10_s2;
	logic [2*HI_W-1:0]         p11_s2, p11_s3;
	logic [LO_W+HI_W:0]        mid_s3;
	logic [FULL_W-1:0]         full_s4;
	logic [MAG_W-1:0]          mag_c;
	logic [Q_W-1:0]            res_c;
	logic [Q_W-1:0]            p_s5;
	logic                      neg_s1, neg_s2, neg_s3, neg_s4;
	prod_tag_t                 tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;

	assign a_abs = req.a[Q_W-1] ? Q_W'(-$signed(req.a)) : req.a;
	assign b_abs = req.b[Q_W-1] ? Q_W'(-$signed(req.b)) : req.b;

	assign mag_c = (|full_s4[FULL_W-1:FRAC_W+MAG_W]) ? '1
		: full_s4[FRAC_W+MAG_W-1:FRAC_W];
	assign res_c = neg_s4 ? Q_W'(-$signed({1'b0, mag_c})) : {1'b0, mag_c};

	assign rsp.valid = v_s5;
	assign rsp.tag   = tag_s5;
	assign rsp.p     = p_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		am_s1  <= a_abs[MAG_W-1:0];
		bm_s1  <= b_abs[MAG_W-1:0];
		neg_s1 <= req.a[Q_W-1] ^ req.b[Q_W-1];
		tag_s1 <= req.tag;

		p00_s2 <= (2*LO_W)'(am_s1[LO_W-1:0]) * (2*LO_W)'(bm_s1[LO_W-1:0]);
		p01_s2 <= (LO_W+HI_W)'(am_s1[LO_W-1:0]) * (LO_W+HI_W)'(bm_s1[MAG_W-1:LO_W]);
		p10_s2 <= (LO_W+HI_W)'(am_s1[MAG_W-1:LO_W]) * (LO_W+HI_W)'(bm_s1[LO_W-1:0]);
		p11_s2 <= (2*HI_W)'(am_s1[MAG_W-1:LO_W]) * (2*HI_W)'(bm_s1[MAG_W-1:LO_W]);
		neg_s2 <= neg_s1;
		tag_s2 <= tag_s1;

		mid_s3 <= (LO_W+HI_W+1)'(p01_s2) + (LO_W+HI_W+1)'(p10_s2);
		p00_s3 <= p00_s2;
		p11_s3 <= p11_s2;
		neg_s3 <= neg_s2;
		tag_s3 <= tag_s2;

		full_s4 <= {p11_s3, p00_s3} + (FULL_W'(mid_s3) << LO_W);
		neg_s4  <= neg_s3;
		tag_s4  <= tag_s3;

		p_s5   <= res_c;
		tag_s5 <= tag_s4;
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> ##5 rsp.valid)
		else $error("product not delivered after five cycles");
`endif

endmodule

[hw/rtl/jets_iter.sv]
// ----------------------------------------------------------------------------
// jets_iter: escape-time iteration engine
// Sequences z = z^2 + c through the shared multiplier and counts steps
// until the magnitude limit or the step limit is reached.
// ----------------------------------------------------------------------------
module jets_iter import jets_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     q_empty,
	output logic     q_pop,
	input  q_entry_t q_data,
	output logic     res_valid,
	input  logic     res_ready,
	output px_res_t  res
);

	typedef enum logic [2:0] {
		IT_IDLE, IT_ISSUE, IT_WAIT, IT_CHECK, IT_HALF, IT_ADD, IT_DONE
	} it_state_t;

	it_state_t               state_q;
	logic signed [Q_W-1:0]   x_q, y_q, xx_q, yy_q, xy_q, re_q, im_q;
	logic signed [Q_W-1:0]   rr_c;
	logic [ITER_W-1:0]       k_q;
	logic [COORD_W-1:0]      col_q, row_q;
	logic [1:0]              iss_q, got_q;
	logic                    first_q;
	logic                    stop_c;
	mul_req_t                mul_req;
	mul_rsp_t                mul_rsp;

	jets_qmul u_qmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_comb begin
		mul_req.valid = (state_q == IT_ISSUE);
		case (iss_q)
			2'd0: begin
				mul_req.tag = PR_XX;
				mul_req.a   = x_q;
				mul_req.b   = x_q;
			end
			2'd1: begin
				mul_req.tag = PR_YY;
				mul_req.a   = y_q;
				mul_req.b   = y_q;
			end
			default: begin
				mul_req.tag = PR_XY;
				mul_req.a   = x_q;
				mul_req.b   = y_q;
			end
		endcase
	end

	assign rr_c   = sat_q(SUM_W'(xx_q) + SUM_W'(yy_q));
	assign stop_c = (rr_c > LIMIT_Q) || (k_q >= cfg.max_iter);

	assign q_pop     = (state_q == IT_IDLE) && !q_empty;
	assign res_valid = (state_q == IT_DONE);
	assign res.col   = col_q;
	assign res.row   = row_q;
	assign res.k     = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IT_IDLE;
			iss_q   <= '0;
			got_q   <= '0;
			first_q <= 1'b0;
			k_q     <= '0;
			col_q   <= '0;
			row_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			xx_q    <= '0;
			yy_q    <= '0;
			xy_q    <= '0;
			re_q    <= '0;
			im_q    <= '0;
		end else begin
			if (mul_rsp.valid) begin
				got_q <= got_q + 1'b1;
				case (mul_rsp.tag)
					PR_XX:   xx_q <= mul_rsp.p;
					PR_YY:   yy_q <= mul_rsp.p;
					default: xy_q <= mul_rsp.p;
				endcase
			end
			case (state_q)
				IT_IDLE: begin
					if (!q_empty) begin
						x_q     <= q_data.x;
						y_q     <= q_data.y;
						col_q   <= q_data.col;
						row_q   <= q_data.row;
						k_q     <= '0;
						first_q <= 1'b1;
						iss_q   <= '0;
						got_q   <= '0;
						state_q <= IT_ISSUE;
					end
				end
				IT_ISSUE: begin
					iss_q <= iss_q + 1'b1;
					if (iss_q == 2'd2) begin
						state_q <= IT_WAIT;
					end
				end
				IT_WAIT: begin
					if (got_q == 2'd3) begin
						got_q   <= '0;
						state_q <= first_q ? IT_HALF : IT_CHECK;
					end
				end
				IT_CHECK: begin
					state_q <= stop_c ? IT_DONE : IT_HALF;
				end
				IT_HALF: begin
					re_q    <= sat_q(SUM_W'(xx_q) - SUM_W'(yy_q));
					im_q    <= sat_q(SUM_W'(xy_q) + SUM_W'(xy_q));
					first_q <= 1'b0;
					state_q <= IT_ADD;
				end
				IT_ADD: begin
					x_q     <= sat_q(SUM_W'(re_q) + SUM_W'($signed(cfg.c_real)));
					y_q     <= sat_q(SUM_W'(im_q) + SUM_W'($signed(cfg.c_imag)));
					k_q     <= k_q + 1'b1;
					iss_q   <= '0;
					state_q <= IT_ISSUE;
				end
				IT_DONE: begin
					if (res_ready) begin
						state_q <= IT_IDLE;
					end
				end
				default: state_q <= IT_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rsp_window: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.valid |-> (state_q == IT_ISSUE || state_q == IT_WAIT))
		else $error("product returned outside a multiply round");
`endif

endmodule

[hw/rtl/jets_color.sv]
// ----------------------------------------------------------------------------
// jets_color: colour mapping and result register
// Reduces the count modulo a nonzero num_colors one bit per cycle, then picks
// the colour mix; holds the packed result until the transfer.
// ----------------------------------------------------------------------------
module jets_color import jets_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  px_res_t                in_res,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	typedef enum logic [1:0] {CL_IDLE, CL_DIV, CL_MAP, CL_HOLD} cl_state_t;

	cl_state_t           state_q;
	px_res_t             item_q;
	logic [ITER_W-1:0]   rem_q, rem_nx, kr_q;
	logic [3:0]          bit_q;
	logic [ITER_W:0]     trial_c;
	logic [DIV3_W-1:0]   prod_c;
	logic [COLOR_W:0]    dim9_c;
	logic [COLOR_W-1:0]  dim_q, lo_c, hi_c, red_c, green_c, blue_c;
	logic [2:0]          sel_q, mix_c;
	logic                out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	assign in_ready = (state_q == CL_IDLE);

	assign trial_c = {rem_q, item_q.k[bit_q]};
	assign rem_nx  = (trial_c >= cfg.num_colors) ? ITER_W'(trial_c - cfg.num_colors)
		: trial_c[ITER_W-1:0];

	assign prod_c = DIV3_W'(kr_q) * DIV3_W'(DIV3_MUL);
	assign dim9_c = prod_c[DIV3_SH+COLOR_W:DIV3_SH];

	assign lo_c    = dim_q;
	assign hi_c    = 8'hFF - dim_q;
	assign mix_c   = MIX_TABLE[sel_q];
	assign red_c   = mix_c[2] ? hi_c : lo_c;
	assign green_c = mix_c[1] ? hi_c : lo_c;
	assign blue_c  = mix_c[0] ? hi_c : lo_c;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CL_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			item_q      <= '0;
			rem_q       <= '0;
			kr_q        <= '0;
			bit_q       <= '0;
			dim_q       <= '0;
			sel_q       <= '0;
		end else begin
			// in the hold state the result register is reloaded instead
			if (out_valid_q && out_ready && state_q != CL_HOLD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				CL_IDLE: begin
					if (in_valid) begin
						item_q <= in_res;
						rem_q  <= '0;
						bit_q  <= 4'(ITER_W - 1);
						kr_q   <= in_res.k;
						state_q <= (cfg.num_colors == '0) ? CL_MAP : CL_DIV;
					end
				end
				CL_DIV: begin
					rem_q <= rem_nx;
					if (bit_q == '0) begin
						kr_q    <= rem_nx;
						state_q <= CL_MAP;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				CL_MAP: begin
					dim_q   <= (dim9_c > 9'd255) ? 8'hFF : dim9_c[COLOR_W-1:0];
					sel_q   <= kr_q[2:0];
					state_q <= CL_HOLD;
				end
				CL_HOLD: begin
					if (!out_valid_q || out_ready) begin
						out_data_q  <= OUT_TDATA_W'({blue_c, green_c, red_c,
							item_q.k, item_q.row, item_q.col});
						out_valid_q <= 1'b1;
						state_q     <= CL_IDLE;
					end
				end
				default: state_q <= CL_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_load_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == CL_HOLD)
		else $error("result register loaded outside the hold state");
`endif

endmodule

[hw/rtl/julia_escape_time_pixel_unit.sv]
// each iteration: three products through the five-stage shared multiplier, then the
//   update adds; colouring overlaps the next pixel
// reset: configuration returns to its defaults, queue and result register empty
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit: julia set escape-time pixel evaluator
// Front computes the start point, a short queue decouples it from the
// iteration engine, and the colour stage maps the count to a colour.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_unit import jets_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // col[11:0], row[23:12]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // pix_col, pix_row, iter_count,
	                                              // red, green, blue, zero pad
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CADDR_W-1:0]     cfg_addr,
	input  logic [CFG_W-1:0]       cfg_data
);

	cfg_t     cfg_q;
	logic     q_full, q_push, q_empty, q_pop;
	q_entry_t q_wdata, q_rdata;
	logic     res_valid, res_ready;
	px_res_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real     <= 32'd73375043;
			cfg_q.c_imag     <= 32'd1992083;
			cfg_q.x_origin   <= 32'd134217728;
			cfg_q.y_origin   <= 32'd134217728;
			cfg_q.step_x     <= 32'd300249;
			cfg_q.step_y     <= 32'd541200;
			cfg_q.max_iter   <= 10'd160;
			cfg_q.num_colors <= 11'd256;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_addr))
				REG_C_REAL:     cfg_q.c_real     <= cfg_data;
				REG_C_IMAG:     cfg_q.c_imag     <= cfg_data;
				REG_X_ORIGIN:   cfg_q.x_origin   <= cfg_data;
				REG_Y_ORIGIN:   cfg_q.y_origin   <= cfg_data;
				REG_STEP_X:     cfg_q.step_x     <= cfg_data;
				REG_STEP_Y:     cfg_q.step_y     <= cfg_data;
				REG_MAX_ITER:   cfg_q.max_iter   <= cfg_data[ITER_W-1:0];
				REG_NUM_COLORS: cfg_q.num_colors <= cfg_data[NCOL_W-1:0];
				default: ;
			endcase
		end
	end

	jets_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_col   (s_axis_tdata[COORD_W-1:0]),
		.in_row   (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	jets_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	jets_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_data    (q_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	jets_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

[dv/jets_pixel_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jets_pixel_checker: result checker for the julia escape-time pixel unit
// Watches the configuration, pixel and result channels. Keeps a shadow of the
// registers, predicts the escape count and colour of every accepted pixel and
// compares each result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module jets_pixel_checker import jets_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // col, row
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // pix_col, pix_row, iter_count,
	                                              // red, green, blue, zero pad
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CADDR_W-1:0]     cfg_addr,
	input  logic [CFG_W-1:0]       cfg_data,
	output int                     failures,
	output int                     pending
);

	localparam int     FX_FRAC  = 28;
	localparam longint FX_MAX   = (longint'(1) << 43) - 1;
	localparam longint ESCAPE_Q = longint'(ESCAPE_LIMIT) << FX_FRAC;

	localparam logic [31:0] C_RE_RST  = 32'd73375043;
	localparam logic [31:0] C_IM_RST  = 32'd1992083;
	localparam logic [31:0] X_ORG_RST = 32'd134217728;
	localparam logic [31:0] Y_ORG_RST = 32'd134217728;
	localparam logic [31:0] DX_RST    = 32'd300249;
	localparam logic [31:0] DY_RST    = 32'd541200;
	localparam logic [9:0]  ITER_RST  = 10'd160;
	localparam logic [10:0] MOD_RST   = 11'd256;

	// lowest field in the lowest bits, as on the result bus
	typedef struct packed {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [9:0]  iters;
		logic [11:0] row;
		logic [11:0] col;
	} pixel_t;

	logic [31:0] c_re, c_im, x_org, y_org, dx, dy;
	logic [9:0]  iter_cap;
	logic [10:0] modulus;
	pixel_t      expected_pixels[$];
	pixel_t      got, want;

	function automatic longint fx_sat(input longint v);
		if (v > FX_MAX) begin
			return FX_MAX;
		end else if (v < -FX_MAX) begin
			return -FX_MAX;
		end
		return v;
	endfunction

	// magnitude product, truncated toward zero, then saturated
	function automatic longint fx_mul(input longint a, input longint b);
		logic [87:0] prod;
		logic [43:0] ma, mb;
		longint      m;
		ma = 44'(a < 0 ? -a : a);
		mb = 44'(b < 0 ? -b : b);
		prod = (88'(ma) * 88'(mb)) >> FX_FRAC;
		m = (prod > 88'(FX_MAX)) ? FX_MAX : longint'(prod[63:0]);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic pixel_t julia_pixel(input logic [11:0] col, input logic [11:0] row);
		longint      x, y, xx, yy, xy, mag2;
		int unsigned k, kr, dim;
		logic [7:0]  lo, hi;
		pixel_t      px;
		x = fx_sat(longint'($signed(x_org)) + longint'(col & IDX_MASK) * longint'($signed(dx)));
		y = fx_sat(longint'($signed(y_org)) + longint'(row & IDX_MASK) * longint'($signed(dy)));
		k = 0;
		do begin
			k++;
			xx = fx_mul(x, x);
			yy = fx_mul(y, y);
			xy = fx_mul(x, y);
			x = fx_sat(fx_sat(xx - yy) + longint'($signed(c_re)));
			y = fx_sat(fx_sat(xy + xy) + longint'($signed(c_im)));
			mag2 = fx_sat(fx_mul(x, x) + fx_mul(y, y));
		end while (mag2 <= ESCAPE_Q && k < iter_cap);
		kr = (modulus != 0) ? k % modulus : k;
		dim = (kr / 3 > 255) ? 255 : kr / 3;
		lo = 8'(dim);
		hi = 8'(255 - dim);
		px.col = col;
		px.row = row;
		px.iters = 10'(k);
		case (kr % 8)
			0: {px.red, px.green, px.blue} = {lo, lo, lo};
			1: {px.red, px.green, px.blue} = {hi, lo, lo};
			2: {px.red, px.green, px.blue} = {lo, hi, lo};
			3: {px.red, px.green, px.blue} = {lo, lo, hi};
			4: {px.red, px.green, px.blue} = {hi, hi, lo};
			5: {px.red, px.green, px.blue} = {lo, hi, hi};
			6: {px.red, px.green, px.blue} = {hi, lo, hi};
			default: {px.red, px.green, px.blue} = {hi, hi, hi};
		endcase
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_re = C_RE_RST;
			c_im = C_IM_RST;
			x_org = X_ORG_RST;
			y_org = Y_ORG_RST;
			dx = DX_RST;
			dy = DY_RST;
			iter_cap = ITER_RST;
			modulus = MOD_RST;
			expected_pixels.delete();
			failures = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_addr))
					REG_C_REAL:     c_re = cfg_data;
					REG_C_IMAG:     c_im = cfg_data;
					REG_X_ORIGIN:   x_org = cfg_data;
					REG_Y_ORIGIN:   y_org = cfg_data;
					REG_STEP_X:     dx = cfg_data;
					REG_STEP_Y:     dy = cfg_data;
					REG_MAX_ITER:   iter_cap = cfg_data[9:0];
					REG_NUM_COLORS: modulus = cfg_data[10:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_pixels.push_back(julia_pixel(s_axis_tdata[11:0], s_axis_tdata[23:12]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = pixel_t'(m_axis_tdata[57:0]);
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("result transfer for pixel (%0d, %0d) with none pending",
						got.col, got.row));
				end else begin
					want = expected_pixels.pop_front();
					if (got.col != want.col)
						report_mismatch($sformatf("pix_col %0d, expected %0d", got.col, want.col));
					if (got.row != want.row)
						report_mismatch($sformatf("pix_row %0d, expected %0d", got.row, want.row));
					if (got.iters != want.iters)
						report_mismatch($sformatf("iter_count %0d, expected %0d at (%0d, %0d)",
							got.iters, want.iters, want.col, want.row));
					if (got.red != want.red)
						report_mismatch($sformatf("red %0d, expected %0d at (%0d, %0d)",
							got.red, want.red, want.col, want.row));
					if (got.green != want.green)
						report_mismatch($sformatf("green %0d, expected %0d at (%0d, %0d)",
							got.green, want.green, want.col, want.row));
					if (got.blue != want.blue)
						report_mismatch($sformatf("blue %0d, expected %0d at (%0d, %0d)",
							got.blue, want.blue, want.col, want.row));
				end
			end
		end
		pending = expected_pixels.size();
	end

endmodule

[dv/tb_julia_escape_time_pixel_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_julia_escape_time_pixel_unit: testbench of the julia escape-time pixel unit
// Directed pixels at register extremes (extreme start points, single-step and
// very long iterations, no colour reduction), then random settings and pixels,
// sender and receiver stalling until the last third. A checker predicts results.
// ----------------------------------------------------------------------------
module tb_julia_escape_time_pixel_unit;
	import jets_pkg::*;

	localparam int TOTAL_PIXELS   = 1170;
	localparam int WATCHDOG_LIMIT = 50000;
	localparam int SETTLE_CYCLES  = 200;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CADDR_W-1:0]     cfg_addr = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	int failures, pending;
	int sent = 0;
	int src_idle = 31;
	int sink_idle = 59;
	int stalled_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	julia_escape_time_pixel_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	jets_pixel_checker pixel_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.failures      (failures),
		.pending       (pending)
	);

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rand_around_zero(input int unsigned span);
		return 32'($urandom_range(0, 2 * span)) - 32'(span);
	endfunction

	task automatic write_cfg(input cfg_reg_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
		if (sent < TOTAL_PIXELS / 3) begin
			src_idle = 31;
			sink_idle = 59;
		end else if (sent < 2 * TOTAL_PIXELS / 3) begin
			src_idle = 59;
			sink_idle = 31;
		end else begin
			src_idle = 0;
			sink_idle = 0;
		end
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {row, col};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// sender holds off until every predicted result has been taken
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int  i, n_pixels, iter_cap;
		bit  wide;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults after reset, index extremes
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'hAAA, 12'h555);
		send_pixel(12'h555, 12'hAAA);
		send_pixel(12'd100, 12'd50);
		send_pixel(12'd200, 12'd300);
		wait_idle();

		// extreme start points, single step, no colour reduction
		write_cfg(REG_C_REAL, 32'h8000_0000);
		write_cfg(REG_C_IMAG, 32'h7FFF_FFFF);
		write_cfg(REG_X_ORIGIN, 32'h8000_0000);
		write_cfg(REG_Y_ORIGIN, 32'h7FFF_FFFF);
		write_cfg(REG_STEP_X, 32'h7FFF_FFFF);
		write_cfg(REG_STEP_Y, 32'h8000_0000);
		write_cfg(REG_MAX_ITER, 32'd0);
		write_cfg(REG_NUM_COLORS, 32'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		wait_idle();

		write_cfg(REG_C_REAL, 32'h7FFF_FFFF);
		write_cfg(REG_C_IMAG, 32'h8000_0000);
		write_cfg(REG_X_ORIGIN, 32'h7FFF_FFFF);
		write_cfg(REG_Y_ORIGIN, 32'h8000_0000);
		write_cfg(REG_STEP_X, 32'h8000_0000);
		write_cfg(REG_STEP_Y, 32'h7FFF_FFFF);
		write_cfg(REG_MAX_ITER, 32'd3);
		write_cfg(REG_NUM_COLORS, 32'd1024);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd4095);
		wait_idle();

		// fixed point at the origin: runs to the cap, dim level clipped
		write_cfg(REG_C_REAL, 32'd0);
		write_cfg(REG_C_IMAG, 32'd0);
		write_cfg(REG_X_ORIGIN, 32'd0);
		write_cfg(REG_Y_ORIGIN, 32'd0);
		write_cfg(REG_STEP_X, 32'd0);
		write_cfg(REG_STEP_Y, 32'd0);
		write_cfg(REG_MAX_ITER, 32'd1023);
		write_cfg(REG_NUM_COLORS, 32'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		wait_idle();
		write_cfg(REG_NUM_COLORS, 32'd1024);
		send_pixel(12'd1234, 12'd3210);
		wait_idle();
		write_cfg(REG_MAX_ITER, 32'd765);
		write_cfg(REG_NUM_COLORS, 32'd2047);
		send_pixel(12'd7, 12'd4000);

		while (sent < TOTAL_PIXELS) begin
			wait_idle();
			wide = ($urandom_range(0, 7) == 0);
			write_cfg(REG_C_REAL, wide ? 32'($urandom) : rand_around_zero(1 << 28));
			write_cfg(REG_C_IMAG, wide ? 32'($urandom) : rand_around_zero(1 << 28));
			write_cfg(REG_X_ORIGIN, wide ? 32'($urandom) : rand_around_zero(1 << 29));
			write_cfg(REG_Y_ORIGIN, wide ? 32'($urandom) : rand_around_zero(1 << 29));
			write_cfg(REG_STEP_X, wide ? 32'($urandom) : rand_around_zero(1 << 18));
			write_cfg(REG_STEP_Y, wide ? 32'($urandom) : rand_around_zero(1 << 18));
			iter_cap = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
			write_cfg(REG_MAX_ITER, (32'($urandom) & ~32'h3FF) | 32'(iter_cap));
			write_cfg(REG_NUM_COLORS, (32'($urandom) & ~32'h7FF) |
				32'($urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(0, 16)));
			n_pixels = $urandom_range(20, 80);
			for (i = 0; i < n_pixels; i++) begin
				send_pixel(12'($urandom), 12'($urandom));
				if (i == n_pixels / 2 && $urandom_range(0, 3) == 0)
					wait_idle();
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/jets_pkg.sv
hw/rtl/jets_front.sv
hw/rtl/jets_fifo.sv
hw/rtl/jets_qmul.sv
hw/rtl/jets_iter.sv
hw/rtl/jets_color.sv
hw/rtl/julia_escape_time_pixel_unit.sv
dv/jets_pixel_checker.sv
dv/tb_julia_escape_time_pixel_unit.sv
